// ===== rtl/sorted_code_point_lookup_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sorted code point lookup assertion macros
// implication checks on one clock with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef SORTED_CODE_POINT_LOOKUP_UNIT_ASSERT_SVH
`define SORTED_CODE_POINT_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define SCLU_ASSERT_IMP(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("sclu assertion failed");

// next-cycle implication
`define SCLU_ASSERT_NXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("sclu assertion failed");

`endif

// ===== rtl/sclu_pkg.sv =====
// ----------------------------------------------------------------------------
// sclu_pkg
// sizes, codes and pipeline stage type of the sorted code point lookup
// ----------------------------------------------------------------------------
package sclu_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PROBES      = PTR_W;

  localparam int ENTRY_W = 10;
  localparam int CP_W    = 21;
  localparam int ADV_W   = 8;
  localparam int CNT_W   = 11;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic             wr_ok;
    logic [IDX_W-1:0] slot;
    logic [CP_W-1:0]  cp;
    logic [ADV_W-1:0] adv;
    logic [PTR_W-1:0] low;
    logic [PTR_W-1:0] hi;
    logic [IDX_W-1:0] pivot;
    logic             found;
  } stage_t;

  // midpoint of the half-open window [low, hi)
  function automatic logic [IDX_W-1:0] mid_point(input logic [PTR_W-1:0] low,
                                                 input logic [PTR_W-1:0] hi);
    logic [PTR_W:0] sum;
    sum = {1'b0, low} + {1'b0, hi} - (PTR_W + 1)'(1);
    return IDX_W'(sum >> 1);
  endfunction

endpackage

// ===== rtl/sclu_ram.sv =====
// ----------------------------------------------------------------------------
// sclu_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module sclu_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sorted_code_point_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// sorted code point lookup unit: pipelined binary search over a glyph table
// throughput one item per cycle unless a stalled result holds the pipeline;
// one table probe per stage, each its own ram
// synchronous reset clears valid bits and sets glyph_count to 1, tables keep
// ----------------------------------------------------------------------------
`include "sorted_code_point_lookup_unit_assert.svh"

module sorted_code_point_lookup_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel (glyph_count)
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sclu_pkg::CNT_W-1:0]  cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [sclu_pkg::ENTRY_W-1:0] entry_index,
  input  logic [sclu_pkg::CP_W-1:0]   code_point,
  input  logic [sclu_pkg::ADV_W-1:0]  advance_in,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sclu_pkg::ENTRY_W-1:0] glyph_index,
  output logic [sclu_pkg::ADV_W-1:0]  advance_width,
  output logic                        found
);

  import sclu_pkg::*;

  // glyph_count register and its clamp to the table depth
  logic [CNT_W-1:0] glyph_count;
  logic [PTR_W-1:0] count_sat;

  // whole pipeline moves together; a stall freezes every stage and ram read
  logic advance;

  // s[k] holds the item after probe k was issued; s[PROBES] is the result
  stage_t s      [PROBES+1];
  stage_t s_next [PROBES+1];

  // registered read data of each stage's copy of the code table
  logic [CP_W-1:0]  probe_data [PROBES];
  logic [ADV_W-1:0] adv_data;

  // shorthands for the checks at the end
  logic stall_out;
  logic window_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      glyph_count <= cfg_data;
    end
  end

  always_comb begin
    if (32'(glyph_count) > TABLE_DEPTH) begin
      count_sat = PTR_W'(TABLE_DEPTH);
    end else begin
      count_sat = PTR_W'(glyph_count);
    end
  end

  // a result waiting in the last stage blocks the pipeline only when not taken
  assign out_valid = s[PROBES].valid && (s[PROBES].kind == KIND_QUERY);
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;

  // entry stage: window [0, count) and the first midpoint
  always_comb begin
    s_next[0].valid = in_valid;
    s_next[0].kind  = kind;
    s_next[0].wr_ok = (32'(entry_index) < TABLE_DEPTH);
    s_next[0].slot  = IDX_W'(entry_index);
    s_next[0].cp    = code_point;
    s_next[0].adv   = advance_in;
    s_next[0].low   = '0;
    s_next[0].hi    = count_sat;
    s_next[0].pivot = mid_point('0, count_sat);
    s_next[0].found = 1'b0;
  end

  // probe stages: compare the probed code point, shrink the window, issue the
  // next midpoint; after a hit the pivot is frozen as the result index
  for (genvar k = 1; k <= PROBES; k++) begin : g_step
    always_comb begin
      stage_t cur;
      cur = s[k-1];
      if ((cur.kind == KIND_QUERY) && !cur.found && (cur.low < cur.hi)) begin
        if (probe_data[k-1] > cur.cp) begin
          cur.hi = PTR_W'(cur.pivot);
        end else if (probe_data[k-1] < cur.cp) begin
          cur.low = PTR_W'(cur.pivot) + PTR_W'(1);
        end else begin
          cur.found = 1'b1;
        end
        if (!cur.found) begin
          cur.pivot = mid_point(cur.low, cur.hi);
        end
      end
      // the last stage turns the pivot into the result index (0 on a miss)
      if ((k == PROBES) && !cur.found) begin
        cur.pivot = '0;
      end
      s_next[k] = cur;
    end
  end

  for (genvar k = 0; k <= PROBES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        s[k].valid <= 1'b0;
      end else if (advance) begin
        s[k] <= s_next[k];
      end
    end
  end

  // one copy of the code table per probe stage; a load writes each copy as it
  // passes, so later queries see it and earlier ones do not
  for (genvar k = 0; k < PROBES; k++) begin : g_code_ram
    sclu_ram #(
      .WIDTH (CP_W),
      .DEPTH (TABLE_DEPTH)
    ) u_code_ram (
      .clk   (clk),
      .we    (advance && s_next[k].valid && (s_next[k].kind == KIND_LOAD) &&
              s_next[k].wr_ok),
      .waddr (s_next[k].slot),
      .wdata (s_next[k].cp),
      .re    (advance && s_next[k].valid && (s_next[k].kind == KIND_QUERY)),
      .raddr (s_next[k].pivot),
      .rdata (probe_data[k])
    );
  end

  // advance width table, read once at the result index
  sclu_ram #(
    .WIDTH (ADV_W),
    .DEPTH (TABLE_DEPTH)
  ) u_adv_ram (
    .clk   (clk),
    .we    (advance && s_next[PROBES].valid && (s_next[PROBES].kind == KIND_LOAD) &&
            s_next[PROBES].wr_ok),
    .waddr (s_next[PROBES].slot),
    .wdata (s_next[PROBES].adv),
    .re    (advance && s_next[PROBES].valid && (s_next[PROBES].kind == KIND_QUERY)),
    .raddr (s_next[PROBES].pivot),
    .rdata (adv_data)
  );

  assign glyph_index   = ENTRY_W'(s[PROBES].pivot);
  assign advance_width = adv_data;
  assign found         = s[PROBES].found;

  assign stall_out    = out_valid && !out_ready;
  assign window_empty = (s[PROBES].low >= s[PROBES].hi);

  // a miss always returns entry 0
  `SCLU_ASSERT_IMP(a_miss_index_zero, clk, rst, out_valid && !found, glyph_index == '0)
  // enough probes: an unresolved search has an empty window at the end
  `SCLU_ASSERT_IMP(a_window_empty, clk, rst, out_valid && !found, window_empty)
  // a stall freezes the last stage, including the ram-held advance width
  `SCLU_ASSERT_NXT(a_stall_holds, clk, rst, stall_out, $stable(adv_data) && $stable(glyph_index))

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// sorted code point lookup unit testbench
// loads sorted glyph tables, sets glyph_count across its range and checks
// every lookup against a binary search kept in step with the accepted loads
// ----------------------------------------------------------------------------
module tb_top;
  import sclu_pkg::*;

  // top of the unicode code space, used when building tables
  localparam logic [CP_W-1:0] CODE_SPACE_TOP = 21'h10FFFF;
  localparam logic [CP_W-1:0] CODE_FIELD_TOP = 21'h1FFFFF;
  // cycles to let loads clear the probe stages before a register write
  localparam int SETTLE_CYCLES = 2 * (PROBES + 1) + 4;
  // cycles with no transaction on any channel before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  localparam int TRAFFIC_PER_PHASE = 10;

  typedef struct {
    logic               kind;
    logic [ENTRY_W-1:0] slot;
    logic [CP_W-1:0]    cp;
    logic [ADV_W-1:0]   adv;
  } glyph_item_t;

  typedef struct {
    logic [ENTRY_W-1:0] index;
    logic [ADV_W-1:0]   advance;
    logic               hit;
  } glyph_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = KIND_LOAD;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic [CP_W-1:0]    code_point = '0;
  logic [ADV_W-1:0]   advance_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ENTRY_W-1:0] glyph_index;
  logic [ADV_W-1:0]   advance_width;
  logic               found;

  sorted_code_point_lookup_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .entry_index   (entry_index),
    .code_point    (code_point),
    .advance_in    (advance_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .glyph_index   (glyph_index),
    .advance_width (advance_width),
    .found         (found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shared state
  // --------------------------------------------------------------------------
  glyph_item_t pending_items[$];   // items waiting for the driver
  glyph_hit_t  lookups_due[$];     // predicted lookup answers, oldest first
  int          mismatches = 0;

  // table as the stimulus generator believes it will be once queued loads land
  logic [CP_W-1:0]  plan_code [TABLE_DEPTH];
  logic [ADV_W-1:0] plan_adv  [TABLE_DEPTH];

  // table and count as the block holds them, updated on accepted transactions
  logic [CP_W-1:0]  code_mem [TABLE_DEPTH];
  logic [ADV_W-1:0] adv_mem  [TABLE_DEPTH];
  logic [CNT_W-1:0] glyph_limit;

  // --------------------------------------------------------------------------
  // prediction: plain binary search over the first glyph_count entries
  // --------------------------------------------------------------------------
  function automatic glyph_hit_t search_glyph(input logic [CP_W-1:0] cp);
    glyph_hit_t res;
    int lo;
    int hi;
    int mid;
    lo = 0;
    // count saturates at the table depth, zero means an empty table
    hi = ((glyph_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(glyph_limit)) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (code_mem[mid] > cp) begin
        hi = mid - 1;
      end else if (code_mem[mid] < cp) begin
        lo = mid + 1;
      end else begin
        res.index   = ENTRY_W'(mid);
        res.advance = adv_mem[mid];
        res.hit     = 1'b1;
        return res;
      end
    end
    // a miss, including a search that runs below entry 0, reports entry 0
    res.index   = '0;
    res.advance = adv_mem[0];
    res.hit     = 1'b0;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of random length with random gaps in between
  // --------------------------------------------------------------------------
  glyph_item_t drive_item;
  int          burst_left;
  int          gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        kind        <= drive_item.kind;
        entry_index <= drive_item.slot;
        code_point  <= drive_item.cp;
        advance_in  <= drive_item.adv;
        in_valid    <= 1'b1;
        if (burst_left == 0) begin
          // a third of the bursts run straight into the next one
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side back-pressure: a stall mode picked anew every so often
  // --------------------------------------------------------------------------
  int stall_mode;
  int mode_left;
  int beat;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
      beat       <= 0;
    end else begin
      beat <= beat + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ((beat % 9) >= 5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: tracks config and loads, predicts lookups, checks results
  // --------------------------------------------------------------------------
  glyph_hit_t want;

  always @(posedge clk) begin
    if (rst) begin
      glyph_limit = 11'd1;
    end else begin
      if (out_valid && out_ready) begin
        if (lookups_due.size() == 0) begin
          flag_mismatch("result with no lookup pending", glyph_index, 0);
        end else begin
          want = lookups_due.pop_front();
          if (glyph_index !== want.index)
            flag_mismatch("glyph_index", glyph_index, want.index);
          if (advance_width !== want.advance)
            flag_mismatch("advance_width", advance_width, want.advance);
          if (found !== want.hit)
            flag_mismatch("found", found, want.hit);
        end
      end
      if (cfg_valid && cfg_ready)
        glyph_limit = cfg_data;
      if (in_valid && in_ready) begin
        if (kind == KIND_LOAD) begin
          code_mem[entry_index] = code_point;
          adv_mem[entry_index]  = advance_in;
        end else begin
          lookups_due.push_back(search_glyph(code_point));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: counts cycles in which no transaction completes anywhere
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_load(input int slot, input logic [CP_W-1:0] cp,
                            input logic [ADV_W-1:0] adv);
    glyph_item_t it;
    it.kind = KIND_LOAD;
    it.slot = ENTRY_W'(slot);
    it.cp   = cp;
    it.adv  = adv;
    plan_code[slot] = cp;
    plan_adv[slot]  = adv;
    pending_items.push_back(it);
  endtask

  task automatic queue_query(input logic [CP_W-1:0] cp);
    glyph_item_t it;
    // slot and advance are don't-care on a lookup, randomize them anyway
    it.kind = KIND_QUERY;
    it.slot = ENTRY_W'($urandom);
    it.cp   = cp;
    it.adv  = ADV_W'($urandom);
    pending_items.push_back(it);
  endtask

  // hold off until the driver is empty and every lookup has answered, then
  // give any trailing loads time to leave the pipeline
  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_valid || lookups_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_glyph_count(input logic [CNT_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ascending table in slots 0..n-1, with the odd duplicate code point
  task automatic fill_sorted(input int n);
    logic [CP_W-1:0] cp;
    int step_top;
    cp = ($urandom_range(0, 3) == 0) ? '0 : CP_W'($urandom_range(0, 1000));
    step_top = (CODE_SPACE_TOP - cp) / n;
    if (step_top < 1)
      step_top = 1;
    for (int s = 0; s < n; s++) begin
      if (s != 0)
        cp = cp + CP_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_top));
      queue_load(s, cp, ADV_W'($urandom));
    end
  endtask

  // mostly well-formed lookups and order-keeping loads, some noise
  task automatic random_traffic(input int n_items, input int eff);
    int span;
    int s;
    int pick;
    logic [CP_W-1:0] lowb;
    logic [CP_W-1:0] upb;
    span = (eff == 0) ? 1 : eff;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, span - 1);
      if (pick < 45) begin
        // exact hit on a live entry
        queue_query(plan_code[s]);
      end else if (pick < 57) begin
        // miss falling between two neighbors
        if (s < span - 1 && plan_code[s] + 1 < plan_code[s + 1])
          queue_query(CP_W'($urandom_range(plan_code[s] + 1, plan_code[s + 1] - 1)));
        else
          queue_query(CP_W'(plan_code[s] + 1));
      end else if (pick < 64) begin
        // below the first entry, the search walks off the bottom
        if (plan_code[0] != 0)
          queue_query(CP_W'($urandom_range(0, plan_code[0] - 1)));
        else
          queue_query('0);
      end else if (pick < 71) begin
        // above the last entry
        if (plan_code[span - 1] != CODE_FIELD_TOP)
          queue_query(CP_W'($urandom_range(plan_code[span - 1] + 1, CODE_FIELD_TOP)));
        else
          queue_query(CODE_FIELD_TOP);
      end else if (pick < 76) begin
        queue_query(CP_W'($urandom));
      end else if (pick < 90) begin
        // reload a live entry without breaking the order
        lowb = (s > 0) ? plan_code[s - 1] : '0;
        upb  = (s < span - 1) ? plan_code[s + 1] : CODE_SPACE_TOP;
        if (lowb > upb)
          queue_load(s, plan_code[s], ADV_W'($urandom));
        else
          queue_load(s, CP_W'($urandom_range(lowb, upb)), ADV_W'($urandom));
      end else if (pick < 95) begin
        // load to a random slot, inside or outside the live region
        queue_load($urandom_range(0, TABLE_DEPTH - 1),
                   CP_W'($urandom_range(0, CODE_SPACE_TOP)), ADV_W'($urandom));
      end else begin
        // unordered load inside the live region
        queue_load(s, CP_W'($urandom_range(0, CODE_SPACE_TOP)), ADV_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input bit refill);
    int eff;
    eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    write_glyph_count(count);
    if (refill)
      fill_sorted(eff);
    random_traffic(TRAFFIC_PER_PHASE, eff);
    drain_and_settle();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, count still at its reset value of one
    queue_load(0, 21'h000041, 8'd8);
    queue_query(21'h000041);
    queue_query(21'h000040);       // below the only entry
    queue_query(21'h000042);
    queue_query('0);
    queue_query(CODE_SPACE_TOP);
    queue_query(CODE_FIELD_TOP);
    queue_load(TABLE_DEPTH - 1, CODE_SPACE_TOP, 8'hFF);
    queue_load(0, '0, '0);
    queue_query('0);
    queue_query(21'h000001);
    queue_load(0, CODE_SPACE_TOP, 8'hFF);
    queue_query(CODE_SPACE_TOP);
    queue_query(21'h0FFFFF);
    queue_query(21'h155555);
    queue_query(21'h0AAAAA);
    drain_and_settle();

    // full sorted table once, then counts that saturate to the table depth
    run_phase(11'd1024, 1'b1);
    run_phase(11'd2047, 1'b0);
    run_phase(11'd1025, 1'b0);
    // smaller tables search a prefix of the full one
    run_phase(CNT_W'($urandom_range(65, 200)), 1'b0);
    run_phase(CNT_W'($urandom_range(17, 64)), 1'b0);
    run_phase(CNT_W'($urandom_range(4, 16)), 1'b0);
    run_phase(11'd3, 1'b0);
    run_phase(11'd2, 1'b0);
    // empty table: every lookup misses on entry 0
    run_phase(11'd0, 1'b0);
    run_phase(11'd1, 1'b0);

    if (mismatches == 0 && lookups_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
